[design/mm3_pkg.sv]
// Shared constants, queue entry type and helper functions for the murmur3 hash unit.
package mm3_pkg;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] N_ADD = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W = 3;

	localparam logic SEED_IDX = 1'b0;

	typedef struct packed {
		logic [31:0] k;
		logic        full;
		logic        last;
		logic [2:0]  add_len;
	} mm3_entry_t;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		rotl15 = {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		rotl13 = {x[18:0], x[31:19]};
	endfunction

	function automatic logic [31:0] tail_mask(input logic [2:0] nb);
		case (nb)
			3'd0:    tail_mask = 32'h0000_0000;
			3'd1:    tail_mask = 32'h0000_00ff;
			3'd2:    tail_mask = 32'h0000_ffff;
			3'd3:    tail_mask = 32'h00ff_ffff;
			default: tail_mask = 32'hffff_ffff;
		endcase
	endfunction

endpackage

[design/mm3_front.sv]
// Front end: accepts key words, classifies them and scrambles the masked word in two stages.
module mm3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	output logic                key_stall,
	input  logic [31:0]         data_word,
	input  logic [2:0]          valid_bytes,
	input  logic                last,
	output logic                push,
	output mm3_pkg::mm3_entry_t push_entry,
	input  logic                queue_full
);
	import mm3_pkg::*;

	logic        v_s1;
	logic        v_s2;
	logic [31:0] k_s1;
	logic        full_s1;
	logic        last_s1;
	logic [2:0]  len_s1;
	mm3_entry_t  entry_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic [2:0]  nb_sat;
	logic        is_full;
	logic [31:0] masked;
	logic [31:0] k2;

	assign ready_s2 = !v_s2 || !queue_full;
	assign ready_s1 = !v_s1 || ready_s2;
	assign key_stall = !ready_s1;

	always_comb begin
		nb_sat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		is_full = !last || (nb_sat == 3'd4);
		masked = is_full ? data_word : (data_word & tail_mask(nb_sat));
		k2 = rotl15(k_s1) * C2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= key_valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && key_valid) begin
			k_s1 <= masked * C1;
			full_s1 <= is_full;
			last_s1 <= last;
			len_s1 <= is_full ? 3'd4 : nb_sat;
		end
		if (ready_s2 && v_s1) begin
			entry_s2.k <= k2;
			entry_s2.full <= full_s1;
			entry_s2.last <= last_s1;
			entry_s2.add_len <= len_s1;
		end
	end

	assign push = v_s2 && !queue_full;
	assign push_entry = entry_s2;

endmodule

[design/mm3_queue.sv]
// Short queue of scrambled words between the front and the back end.
module mm3_queue #(
	parameter int DEPTH = mm3_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mm3_pkg::mm3_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output mm3_pkg::mm3_entry_t head
);
	import mm3_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	mm3_entry_t    slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == DEPTH_C);
	assign avail = (cnt_q != '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

endmodule

[design/mm3_back.sv]
// Back end: hash recurrence, length count, pipelined finalizer and output register.
module mm3_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed,
	input  logic                avail,
	input  mm3_pkg::mm3_entry_t head,
	output logic                pop,
	output logic                hash_valid,
	input  logic                hash_stall,
	output logic [31:0]         hash_value
);
	import mm3_pkg::*;

	logic        key_start_q;
	logic [31:0] h_q;
	logic [31:0] len_q;
	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic [31:0] f_s1;
	logic [31:0] f_s2;
	logic [31:0] f_s3;
	logic        ready_out;
	logic        ready_s3;
	logic        ready_s2;
	logic        ready_s1;
	logic [31:0] h_cur;
	logic [31:0] len_cur;
	logic [31:0] h_mix;
	logic [31:0] h_rot;
	logic [31:0] h_next;
	logic [31:0] len_next;
	logic [31:0] a1;
	logic [31:0] a2;

	assign ready_out = !hash_valid || !hash_stall;
	assign ready_s3 = !v_s3 || ready_out;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign pop = avail && ready_s1;

	always_comb begin
		h_cur = key_start_q ? seed : h_q;
		len_cur = key_start_q ? 32'd0 : len_q;
		h_mix = h_cur ^ head.k;
		h_rot = rotl13(h_mix);
		h_next = head.full ? ((h_rot << 2) + h_rot + N_ADD) : h_mix;
		len_next = len_cur + {29'd0, head.add_len};
		a1 = f_s1 ^ (f_s1 >> 16);
		a2 = f_s2 ^ (f_s2 >> 13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_start_q <= 1'b1;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			hash_valid <= 1'b0;
		end else begin
			if (pop) key_start_q <= head.last;
			if (ready_s1) v_s1 <= pop && head.last;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_out) hash_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head.last) begin
			h_q <= h_next;
			len_q <= len_next;
		end
		if (pop && head.last) f_s1 <= h_next ^ len_next;
		if (ready_s2 && v_s1) f_s2 <= a1 * F1;
		if (ready_s3 && v_s2) f_s3 <= a2 * F2;
		if (ready_out && v_s3) hash_value <= f_s3 ^ (f_s3 >> 16);
	end

endmodule

[design/murmur3_hash_32_unit.sv]
// Top level of the streaming 32-bit murmur3 hash unit with its seed register.
//
// Key words enter on the key channel (key_valid, key_stall, data_word, valid_bytes,
// last); a transfer happens at a clock edge with key_valid high and key_stall low.
// Words are little-endian; valid_bytes counts only on the word marked last.
// One finalized hash leaves per key on the hash channel (hash_valid, hash_stall,
// hash_value), held from an output register until its transfer.
// The seed register lies at addresses 0 to 3 of the APB port (paddr[2] low) and is
// loaded at the start of each key; write it only while the unit is idle.
// Throughput is one word per cycle unless a stall holds it, set by the hash recurrence
// in the back end; the word scramble runs ahead in a two-stage front pipeline.
// From the transfer of the last word to hash_valid, a key passes both scramble stages,
// the queue write, the recurrence, the finalizer stages and the output register.
// Reset empties both pipelines and the queue and clears the seed to zero.
// While the receiver stalls, the finalizer, the queue and the front stages fill first;
// then key_stall rises and no word is taken until space frees up.
module murmur3_hash_32_unit #(
	parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mm3_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        key_valid,
	output logic                        key_stall,
	input  logic [31:0]                 data_word,
	input  logic [2:0]                  valid_bytes,
	input  logic                        last,
	output logic                        hash_valid,
	input  logic                        hash_stall,
	output logic [31:0]                 hash_value
);
	import mm3_pkg::*;

	logic        seed_sel;
	logic [31:0] seed_val_q;
	logic        push;
	mm3_entry_t  push_entry;
	logic        queue_full;
	logic        pop;
	logic        avail;
	mm3_entry_t  head;

	assign pready = 1'b1;
	assign seed_sel = (paddr[ADDR_W-1] == SEED_IDX);
	assign prdata = seed_sel ? seed_val_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_val_q <= 32'd0;
		end else if (psel && penable && pwrite && seed_sel) begin
			seed_val_q <= pwdata;
		end
	end

	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.data_word  (data_word),
		.valid_bytes(valid_bytes),
		.last       (last),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	mm3_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	mm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_val_q),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.hash_valid(hash_valid),
		.hash_stall(hash_stall),
		.hash_value(hash_value)
	);

endmodule
